[rtl/core/blzr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blzr_pkg: shared types and constants
// Widths, register codes and the controller/datapath interface of the
// Bresenham line rasterizer with depth test.
// ----------------------------------------------------------------------------
package blzr_pkg;

    localparam int CRD_W     = 14;      // signed endpoint coordinate
    localparam int SCR_W     = 13;      // screen width / height
    localparam int SPAN_W    = 14;      // |dx|, |dy|
    localparam int ERR_W     = 17;      // Bresenham error term
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int DCNT_W    = 5;
    localparam int DEP_W     = 16;
    localparam int COL_W     = 24;
    localparam int FB_AW     = 16;
    localparam int FB_DEPTH  = 1 << FB_AW;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCR_W-1:0] SCR_RESET = SCR_W'(256);
    localparam logic [DEP_W-1:0] DEP_MIN   = {1'b1, {(DEP_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic div_step;
        logic div_first;
        logic mul_en;
        logic sum_en;
        logic rd_en;
        logic cmp_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_pixel;
    } dp_sts_t;

endpackage
`default_nettype wire

[rtl/core/bresenham_line_zbuffer_raster_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_zbuffer_raster_core: line rasterizer with depth test
// After reset the 65536-entry z-buffer is swept to the minimum depth, one
// entry per cycle, before the first item is taken. A load item or an
// idle/off-screen step skips to the output stage; an on-screen step first
// runs the 17-step radix-2 divider that forms the interpolation fraction,
// then multiply, sum, z-buffer read and depth test.
// One item is worked at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module bresenham_line_zbuffer_raster_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [blzr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [blzr_pkg::SCR_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_operation,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_start_x,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_start_y,
    input  wire logic signed [blzr_pkg::DEP_W-1:0]   s_start_depth,
    input  wire logic [blzr_pkg::COL_W-1:0]          s_start_color,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_end_x,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_end_y,
    input  wire logic signed [blzr_pkg::DEP_W-1:0]   s_end_depth,
    input  wire logic [blzr_pkg::COL_W-1:0]          s_end_color,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_pixel_write,
    output logic [blzr_pkg::FB_AW-1:0]               m_pixel_index,
    output logic [blzr_pkg::COL_W-1:0]               m_pixel_color,
    output logic signed [blzr_pkg::DEP_W-1:0]        m_pixel_depth,
    output logic                                     m_line_done
);

    blzr_pkg::dp_cmd_t cmd;
    blzr_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    blzr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    blzr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_operation   (s_operation),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_start_depth (s_start_depth),
        .s_start_color (s_start_color),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_end_depth   (s_end_depth),
        .s_end_color   (s_end_color),
        .m_pixel_write (m_pixel_write),
        .m_pixel_index (m_pixel_index),
        .m_pixel_color (m_pixel_color),
        .m_pixel_depth (m_pixel_depth),
        .m_line_done   (m_line_done)
    );

endmodule
`default_nettype wire

[rtl/core/blzr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blzr_ctrl: rasterizer controller
// Sequences the z-buffer clear, the fraction divider, interpolation, the
// depth test and the output register handshake.
// ----------------------------------------------------------------------------
module blzr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire blzr_pkg::dp_sts_t sts,
    output blzr_pkg::dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_MUL, ST_SUM, ST_RD, ST_CMP, ST_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [blzr_pkg::DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            s_fire;
    logic                            out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        dcnt_next    = dcnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    cmd.accept = 1'b1;
                    dcnt_next  = '0;
                    state_next = sts.need_pixel ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (dcnt_reg == '0);
                dcnt_next     = dcnt_reg + 1'b1;
                if (dcnt_reg == blzr_pkg::DCNT_W'(blzr_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_RD;
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over a waiting transfer");
    a_clear_no_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !cmd.accept)
        else $error("item taken during z-buffer clear");
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dcnt_reg < blzr_pkg::DCNT_W'(blzr_pkg::DIV_STEPS)))
        else $error("divider ran past its last step");
    a_valid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

[rtl/core/blzr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blzr_dp: rasterizer datapath
// Line state, Bresenham stepping, radix-2 fraction divider, depth and color
// interpolation, z-buffer memory and result registers.
// ----------------------------------------------------------------------------
module blzr_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire blzr_pkg::dp_cmd_t                   cmd,
    output blzr_pkg::dp_sts_t                        sts,
    input  wire logic                                cfg_valid,
    input  wire logic [blzr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [blzr_pkg::SCR_W-1:0]          cfg_data,
    input  wire logic                                s_operation,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_start_x,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_start_y,
    input  wire logic signed [blzr_pkg::DEP_W-1:0]   s_start_depth,
    input  wire logic [blzr_pkg::COL_W-1:0]          s_start_color,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_end_x,
    input  wire logic signed [blzr_pkg::CRD_W-1:0]   s_end_y,
    input  wire logic signed [blzr_pkg::DEP_W-1:0]   s_end_depth,
    input  wire logic [blzr_pkg::COL_W-1:0]          s_end_color,
    output logic                                     m_pixel_write,
    output logic [blzr_pkg::FB_AW-1:0]               m_pixel_index,
    output logic [blzr_pkg::COL_W-1:0]               m_pixel_color,
    output logic signed [blzr_pkg::DEP_W-1:0]        m_pixel_depth,
    output logic                                     m_line_done
);

    localparam int CW  = blzr_pkg::CRD_W;
    localparam int SW  = blzr_pkg::SPAN_W;
    localparam int EW  = blzr_pkg::ERR_W;
    localparam int QW  = blzr_pkg::QUO_W;
    localparam int DW  = blzr_pkg::DEP_W;
    localparam int AW  = blzr_pkg::FB_AW;
    localparam int FW  = blzr_pkg::FRAC_W;
    localparam int NW  = blzr_pkg::SCR_W;

    // configuration
    logic [NW-1:0] width_reg, height_reg;

    // line state
    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg, cx_reg, cy_reg;
    logic signed [DW-1:0] d0_reg, d1_reg;
    logic [blzr_pkg::COL_W-1:0] c0_reg, c1_reg;
    logic [SW-1:0]        dx_reg, dy_reg;
    logic                 sxn_reg, syn_reg, major_x_reg;
    logic signed [EW-1:0] err_reg;
    logic                 active_reg;

    // per-pixel work
    logic [NW-1:0]        px_reg, py_reg;
    logic [SW-1:0]        pos_reg, span_reg, rem_reg;
    logic [QW-1:0]        quo_reg;
    logic signed [DW+QW+1:0] dprod_reg;
    logic signed [8+QW+1:0]  cprod_reg [3];
    logic [2*NW-1:0]      iprod_reg;
    logic [AW-1:0]        idx_reg;
    logic signed [DW-1:0] dep_reg, rd_data_reg;
    logic [blzr_pkg::COL_W-1:0] col_reg;
    logic                 res_wr_reg, res_done_reg;
    logic [AW-1:0]        clr_cnt_reg;

    logic signed [DW-1:0] zbuf [blzr_pkg::FB_DEPTH];

    // ---------------- accept-time logic ----------------
    logic signed [CW:0]   wext, hext;
    logic signed [CW:0]   ldx_s, ldy_s;
    logic [SW-1:0]        ldx, ldy;
    logic                 lrej, lactive;
    logic                 onscreen;
    logic signed [EW:0]   e2;
    logic                 stx, sty;
    logic signed [EW-1:0] err_n;
    logic signed [CW-1:0] xn, yn;
    logic                 active_n;
    logic signed [CW:0]   pdx_s, pdy_s;
    logic [SW-1:0]        pdx, pdy;

    assign wext  = $signed({2'b00, width_reg});
    assign hext  = $signed({2'b00, height_reg});
    assign ldx_s = CW'(0) + (CW+1)'(s_end_x) - (CW+1)'(s_start_x);
    assign ldy_s = (CW+1)'(s_end_y) - (CW+1)'(s_start_y);
    assign ldx   = ldx_s[CW] ? SW'(-ldx_s) : SW'(ldx_s);
    assign ldy   = ldy_s[CW] ? SW'(-ldy_s) : SW'(ldy_s);
    assign lrej  = (s_start_x < 0 && s_end_x < 0) || (s_start_y < 0 && s_end_y < 0)
                || ((CW+1)'(s_start_x) >= wext && (CW+1)'(s_end_x) >= wext)
                || ((CW+1)'(s_start_y) >= hext && (CW+1)'(s_end_y) >= hext);
    assign lactive = !lrej && (s_start_x != s_end_x || s_start_y != s_end_y);

    assign onscreen = (cx_reg >= 0) && (cy_reg >= 0)
                   && ((CW+1)'(cx_reg) < wext) && ((CW+1)'(cy_reg) < hext);

    assign e2    = (EW+1)'(err_reg) <<< 1;
    assign stx   = e2 >= -$signed({(EW+1-SW)'(0), dy_reg});
    assign sty   = e2 <= $signed({(EW+1-SW)'(0), dx_reg});
    assign err_n = err_reg - (stx ? $signed({(EW-SW)'(0), dy_reg}) : EW'(0))
                           + (sty ? $signed({(EW-SW)'(0), dx_reg}) : EW'(0));
    assign xn    = stx ? (sxn_reg ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
    assign yn    = sty ? (syn_reg ? cy_reg - 1'b1 : cy_reg + 1'b1) : cy_reg;
    assign active_n = !(xn == x1_reg && yn == y1_reg);

    assign pdx_s = (CW+1)'(cx_reg) - (CW+1)'(x0_reg);
    assign pdy_s = (CW+1)'(cy_reg) - (CW+1)'(y0_reg);
    assign pdx   = pdx_s[CW] ? SW'(-pdx_s) : SW'(pdx_s);
    assign pdy   = pdy_s[CW] ? SW'(-pdy_s) : SW'(pdy_s);

    assign sts.need_pixel = (s_operation == blzr_pkg::OP_STEP) && active_reg && onscreen;
    assign sts.clear_last = (clr_cnt_reg == {AW{1'b1}});

    // ---------------- divider step ----------------
    logic [SW:0] rem2, rem_sub;
    logic        q_ge;
    assign rem2    = cmd.div_first ? {1'b0, pos_reg} : {rem_reg, 1'b0};
    assign q_ge    = rem2 >= {1'b0, span_reg};
    assign rem_sub = rem2 - {1'b0, span_reg};

    // ---------------- interpolation sums ----------------
    logic signed [DW+QW+2:0] dnum;
    logic signed [DW-1:0]    dep_t;
    logic [blzr_pkg::COL_W-1:0] col_t;
    logic signed [8+QW+2:0]  cnum [3];
    assign dnum  = ((DW+QW+3)'(d0_reg) <<< FW) + (DW+QW+3)'(dprod_reg);
    assign dep_t = dnum[FW+DW-1:FW]
                 + DW'(dnum[DW+QW+2] && (dnum[FW-1:0] != '0));
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cnum[i] = $signed({4'b0000, c0_reg[8*i +: 8], {FW{1'b0}}})
                    + (8+QW+3)'(cprod_reg[i]);
            col_t[8*i +: 8] = cnum[i][FW +: 8];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= blzr_pkg::SCR_RESET;
            height_reg  <= blzr_pkg::SCR_RESET;
            x0_reg <= '0; y0_reg <= '0; x1_reg <= '0; y1_reg <= '0;
            cx_reg <= '0; cy_reg <= '0;
            d0_reg <= '0; d1_reg <= '0; c0_reg <= '0; c1_reg <= '0;
            dx_reg <= '0; dy_reg <= '0;
            sxn_reg <= 1'b0; syn_reg <= 1'b0; major_x_reg <= 1'b0;
            err_reg     <= '0;
            active_reg  <= 1'b0;
            clr_cnt_reg <= '0;
            m_pixel_write <= 1'b0;
            m_line_done   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == blzr_pkg::CFG_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == blzr_pkg::CFG_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept) begin
                if (s_operation == blzr_pkg::OP_LOAD) begin
                    x0_reg <= s_start_x; y0_reg <= s_start_y;
                    x1_reg <= s_end_x;   y1_reg <= s_end_y;
                    cx_reg <= s_start_x; cy_reg <= s_start_y;
                    d0_reg <= s_start_depth; d1_reg <= s_end_depth;
                    c0_reg <= s_start_color; c1_reg <= s_end_color;
                    dx_reg <= ldx; dy_reg <= ldy;
                    sxn_reg <= !(s_start_x < s_end_x);
                    syn_reg <= !(s_start_y < s_end_y);
                    major_x_reg <= ldx > ldy;
                    err_reg <= $signed({(EW-SW)'(0), ldx}) - $signed({(EW-SW)'(0), ldy});
                    active_reg <= lactive;
                end else if (active_reg) begin
                    // advance one Bresenham step
                    cx_reg <= xn; cy_reg <= yn;
                    err_reg <= err_n;
                    active_reg <= active_n;
                end
            end
            if (cmd.out_load) begin
                m_pixel_write <= res_wr_reg;
                m_line_done   <= res_done_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg   <= NW'(cx_reg);
            py_reg   <= NW'(cy_reg);
            pos_reg  <= major_x_reg ? pdx : pdy;
            span_reg <= major_x_reg ? dx_reg : dy_reg;
            res_wr_reg <= 1'b0;
            if (s_operation == blzr_pkg::OP_LOAD) begin
                res_done_reg <= !lactive;
            end else begin
                res_done_reg <= !(active_reg && active_n);
            end
        end
        if (cmd.div_step) begin
            rem_reg <= q_ge ? rem_sub[SW-1:0] : rem2[SW-1:0];
            quo_reg <= {quo_reg[QW-2:0], q_ge};
        end
        if (cmd.mul_en) begin
            dprod_reg <= ((DW+1)'(d1_reg) - (DW+1)'(d0_reg)) * $signed({1'b0, quo_reg});
            for (int i = 0; i < 3; i++) begin
                cprod_reg[i] <= ($signed({1'b0, c1_reg[8*i +: 8]})
                               - $signed({1'b0, c0_reg[8*i +: 8]}))
                              * $signed({1'b0, quo_reg});
            end
            iprod_reg <= py_reg * width_reg;
        end
        if (cmd.sum_en) begin
            dep_reg <= dep_t;
            col_reg <= col_t;
            idx_reg <= iprod_reg[AW-1:0] + AW'(px_reg);
        end
        if (cmd.rd_en) begin
            rd_data_reg <= zbuf[idx_reg];
        end
        if (cmd.cmp_en && (rd_data_reg < dep_reg)) begin
            res_wr_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_pixel_index <= res_wr_reg ? idx_reg : '0;
            m_pixel_color <= res_wr_reg ? col_reg : '0;
            m_pixel_depth <= res_wr_reg ? dep_reg : '0;
        end
    end

    // z-buffer: one write port shared by the clear sweep and the depth test
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            zbuf[clr_cnt_reg] <= blzr_pkg::DEP_MIN;
        end else if (cmd.cmp_en && (rd_data_reg < dep_reg)) begin
            zbuf[idx_reg] <= dep_reg;
        end
    end

`ifndef SYNTHESIS
    a_span_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_first |-> (span_reg != '0))
        else $error("divide by zero span");
    a_pos_le: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_first |-> (pos_reg <= span_reg))
        else $error("pixel beyond line span");
    a_quo_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> (quo_reg <= QW'(1 << FW)))
        else $error("fraction above one");
`endif

endmodule
`default_nettype wire

[verif/blzr_checker.sv]
// ----------------------------------------------------------------------------
// blzr_checker: result checker for the line rasterizer
// Watches the register, input and result channels. Keeps its own copy of the
// screen size, the active line, the Bresenham walk and the z-buffer. It works
// out the pixel that each input transfer should give and compares every
// result transfer, field by field, with the oldest pixel still waiting.
// ----------------------------------------------------------------------------
module blzr_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [blzr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [blzr_pkg::SCR_W-1:0]        cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_operation,
    input  logic signed [blzr_pkg::CRD_W-1:0] s_start_x,
    input  logic signed [blzr_pkg::CRD_W-1:0] s_start_y,
    input  logic signed [blzr_pkg::DEP_W-1:0] s_start_depth,
    input  logic [blzr_pkg::COL_W-1:0]        s_start_color,
    input  logic signed [blzr_pkg::CRD_W-1:0] s_end_x,
    input  logic signed [blzr_pkg::CRD_W-1:0] s_end_y,
    input  logic signed [blzr_pkg::DEP_W-1:0] s_end_depth,
    input  logic [blzr_pkg::COL_W-1:0]        s_end_color,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_pixel_write,
    input  logic [blzr_pkg::FB_AW-1:0]        m_pixel_index,
    input  logic [blzr_pkg::COL_W-1:0]        m_pixel_color,
    input  logic signed [blzr_pkg::DEP_W-1:0] m_pixel_depth,
    input  logic                              m_line_done,
    output int                                fail_count,
    output int                                pixels_pending
);

    typedef struct {
        logic                       wr;
        logic [blzr_pkg::FB_AW-1:0] idx;
        logic [blzr_pkg::COL_W-1:0] col;
        logic [blzr_pkg::DEP_W-1:0] dep;
        logic                       done;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic signed [blzr_pkg::DEP_W-1:0] zbuf [blzr_pkg::FB_DEPTH];
    int          ln_x0, ln_y0, ln_x1, ln_y1, ln_d0, ln_d1;
    logic [23:0] ln_c0, ln_c1;
    int          cur_x, cur_y, bres_err;
    bit          drawing;
    int          scr_w, scr_h;

    function automatic longint blend(longint s, longint e, longint f);
        return (s * 65536 + (e - s) * f) / 65536;
    endfunction

    function automatic int mag(int v);
        return v < 0 ? -v : v;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        fail_count++;
    endtask

    task automatic rasterize_item();
        pixel_t p;
        int dx, dy, sx, sy, e2;
        longint pos, span, frac, idx, dep;
        p = '{wr: 0, idx: '0, col: '0, dep: '0, done: 1};
        if (s_operation == blzr_pkg::OP_LOAD) begin
            ln_x0 = s_start_x; ln_y0 = s_start_y;
            ln_x1 = s_end_x;   ln_y1 = s_end_y;
            ln_d0 = s_start_depth; ln_d1 = s_end_depth;
            ln_c0 = s_start_color; ln_c1 = s_end_color;
            cur_x = ln_x0; cur_y = ln_y0;
            bres_err = mag(ln_x1 - ln_x0) - mag(ln_y1 - ln_y0);
            drawing = !((ln_x0 < 0 && ln_x1 < 0) || (ln_y0 < 0 && ln_y1 < 0)
                     || (ln_x0 >= scr_w && ln_x1 >= scr_w)
                     || (ln_y0 >= scr_h && ln_y1 >= scr_h))
                   && (ln_x0 != ln_x1 || ln_y0 != ln_y1);
            p.done = !drawing;
        end else if (drawing) begin
            dx = mag(ln_x1 - ln_x0);
            dy = mag(ln_y1 - ln_y0);
            sx = ln_x0 < ln_x1 ? 1 : -1;
            sy = ln_y0 < ln_y1 ? 1 : -1;
            if (cur_x >= 0 && cur_y >= 0 && cur_x < scr_w && cur_y < scr_h) begin
                if (dx > dy) begin
                    pos = mag(cur_x - ln_x0); span = dx;
                end else begin
                    pos = mag(cur_y - ln_y0); span = dy;
                end
                frac = (pos << 16) / span;
                dep  = blend(ln_d0, ln_d1, frac);
                idx  = longint'(cur_y) * scr_w + cur_x;
                if (longint'(zbuf[idx[15:0]]) < dep) begin
                    zbuf[idx[15:0]] = dep[15:0];
                    p.wr  = 1;
                    p.idx = idx[15:0];
                    p.dep = dep[15:0];
                    for (int sh = 0; sh <= 16; sh += 8)
                        p.col[sh +: 8] = 8'(blend(ln_c0[sh +: 8], ln_c1[sh +: 8], frac));
                end
            end
            e2 = 2 * bres_err;
            if (e2 >= -dy) begin
                bres_err -= dy; cur_x += sx;
            end
            if (e2 <= dx) begin
                bres_err += dx; cur_y += sy;
            end
            if (cur_x == ln_x1 && cur_y == ln_y1)
                drawing = 0;
            p.done = !drawing;
        end
        expected_pixels.push_back(p);
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            expected_pixels.delete();
            foreach (zbuf[i]) zbuf[i] = blzr_pkg::DEP_MIN;
            ln_x0 = 0; ln_y0 = 0; ln_x1 = 0; ln_y1 = 0; ln_d0 = 0; ln_d1 = 0;
            ln_c0 = '0; ln_c1 = '0;
            cur_x = 0; cur_y = 0; bres_err = 0; drawing = 0;
            scr_w = 256; scr_h = 256;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report("result with none expected", m_pixel_index, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_write !== want.wr) report("pixel_write", m_pixel_write, want.wr);
                    if (m_pixel_index !== want.idx) report("pixel_index", m_pixel_index, want.idx);
                    if (m_pixel_color !== want.col) report("pixel_color", m_pixel_color, want.col);
                    if (m_pixel_depth !== want.dep) report("pixel_depth", m_pixel_depth, want.dep);
                    if (m_line_done !== want.done) report("line_done", m_line_done, want.done);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == blzr_pkg::CFG_WIDTH)
                    scr_w = cfg_data;
                else if (cfg_index == blzr_pkg::CFG_HEIGHT)
                    scr_h = cfg_data;
            end
            if (s_valid && s_ready)
                rasterize_item();
        end
        pixels_pending = expected_pixels.size();
    end

    initial begin
        fail_count = 0;
        pixels_pending = 0;
    end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the line rasterizer with depth test
// Drives directed lines (rejects, coincident ends, extremes, depth test),
// then random short lines near the screen mixed with noise, over several
// screen sizes. Results are checked by blzr_checker.
// ----------------------------------------------------------------------------
module tb_top;

    logic                              aclk = 0;
    logic                              aresetn = 0;
    logic                              cfg_valid = 0;
    logic                              cfg_ready;
    logic [blzr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [blzr_pkg::SCR_W-1:0]        cfg_data = '0;
    logic                              s_valid = 0;
    logic                              s_ready;
    logic                              s_operation = blzr_pkg::OP_STEP;
    logic signed [blzr_pkg::CRD_W-1:0] s_start_x = '0, s_start_y = '0;
    logic signed [blzr_pkg::CRD_W-1:0] s_end_x = '0, s_end_y = '0;
    logic signed [blzr_pkg::DEP_W-1:0] s_start_depth = '0, s_end_depth = '0;
    logic [blzr_pkg::COL_W-1:0]        s_start_color = '0, s_end_color = '0;
    logic                              m_valid;
    logic                              m_ready = 0;
    logic                              m_pixel_write;
    logic [blzr_pkg::FB_AW-1:0]        m_pixel_index;
    logic [blzr_pkg::COL_W-1:0]        m_pixel_color;
    logic signed [blzr_pkg::DEP_W-1:0] m_pixel_depth;
    logic                              m_line_done;
    int                                fail_count, pixels_pending;

    int items_sent = 0;
    int cur_w = 256, cur_h = 256;
    bit quiet = 0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    bresenham_line_zbuffer_raster_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_start_depth(s_start_depth), .s_start_color(s_start_color),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .s_end_depth(s_end_depth), .s_end_color(s_end_color),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_write(m_pixel_write), .m_pixel_index(m_pixel_index),
        .m_pixel_color(m_pixel_color), .m_pixel_depth(m_pixel_depth),
        .m_line_done(m_line_done)
    );

    blzr_checker u_checker (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 12287)) - 4096;
    endfunction

    // Result side: stall at random, none while quiet.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 0;
            stall_left--;
        end else begin
            m_ready <= 1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    task automatic send_item(logic op, int x0, int y0, int d0, int c0,
                             int x1, int y1, int d1, int c1);
        int gap;
        s_valid       <= 1;
        s_operation   <= op;
        s_start_x     <= blzr_pkg::CRD_W'(x0);
        s_start_y     <= blzr_pkg::CRD_W'(y0);
        s_start_depth <= blzr_pkg::DEP_W'(d0);
        s_start_color <= blzr_pkg::COL_W'(c0);
        s_end_x       <= blzr_pkg::CRD_W'(x1);
        s_end_y       <= blzr_pkg::CRD_W'(y1);
        s_end_depth   <= blzr_pkg::DEP_W'(d1);
        s_end_color   <= blzr_pkg::COL_W'(c1);
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_step();
        send_item(blzr_pkg::OP_STEP, rand_coord(), rand_coord(), $urandom, $urandom,
                  rand_coord(), rand_coord(), $urandom, $urandom);
    endtask

    // Load a line, then walk it; extra steps run past the end while idle.
    task automatic trace_line(int x0, int y0, int d0, int c0,
                              int x1, int y1, int d1, int c1, int steps);
        send_item(blzr_pkg::OP_LOAD, x0, y0, d0, c0, x1, y1, d1, c1);
        repeat (steps) send_step();
    endtask

    function automatic int span_of(int x0, int y0, int x1, int y1);
        int ax, ay;
        ax = x1 > x0 ? x1 - x0 : x0 - x1;
        ay = y1 > y0 ? y1 - y0 : y0 - y1;
        return ax > ay ? ax : ay;
    endfunction

    task automatic write_reg(logic [blzr_pkg::CFG_IDX_W-1:0] idx, int val);
        s_valid <= 0;
        // let the checker see the last input transfer before polling
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= blzr_pkg::SCR_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == blzr_pkg::CFG_WIDTH) cur_w = val;
        else cur_h = val;
    endtask

    task automatic random_traffic(int target);
        int kind, x0, y0, x1, y1, rw, rh, d0;
        while (items_sent < target) begin
            kind = $urandom_range(0, 9);
            rw = cur_w < 48 ? cur_w : 48;
            rh = cur_h < 48 ? cur_h : 48;
            if (kind == 0) begin
                trace_line(rand_coord(), rand_coord(), $urandom, $urandom,
                           rand_coord(), rand_coord(), $urandom, $urandom,
                           $urandom_range(0, 3));
            end else if (kind == 1) begin
                send_step();
            end else begin
                x0 = $urandom_range(0, rw + 7) - 4;
                y0 = $urandom_range(0, rh + 7) - 4;
                x1 = $urandom_range(0, rw + 7) - 4;
                y1 = $urandom_range(0, rh + 7) - 4;
                d0 = kind == 2 ? -32768 : int'($urandom_range(0, 65535)) - 32768;
                trace_line(x0, y0, d0, $urandom, x1, y1,
                           int'($urandom_range(0, 65535)) - 32768, $urandom,
                           span_of(x0, y0, x1, y1) + (kind == 3 ? 1 : 0));
            end
        end
    endtask

    initial begin
        int pw[5] = '{64, 1, 4096, 4096, 200};
        int ph[5] = '{48, 4096, 1, 4096, 100};
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // Rejects on each side, coincident ends, step while idle.
        trace_line(-5, 10, 0, 0, -1, 20, 0, 0, 0);
        trace_line(10, -5, 0, 0, 20, -1, 0, 0, 0);
        trace_line(256, 10, 0, 0, 300, 20, 0, 0, 0);
        trace_line(10, 256, 0, 0, 20, 8191, 0, 0, 0);
        trace_line(10, 10, 5, 0, 10, 10, 5, 0, 1);
        // Extreme fields; abandoned after a few off-screen steps.
        trace_line(-4096, -4096, -32768, 0, 8191, 8191, 32767, 'hFFFFFF, 2);
        // Depth from the minimum up; the minimum itself must not pass.
        trace_line(0, 0, -32768, 0, 8, 3, 32767, 'hFFFFFF, 8);
        // Same pixels again at a higher depth: the depth test passes.
        trace_line(0, 0, -100, 'h123456, 8, 3, -100, 'h654321, 3);
        // Steep line walking left, then one entering from off-screen.
        trace_line(5, 0, 1000, 'hFF00FF, 3, 6, -1000, 'h00FF00, 6);
        trace_line(-2, 4, 300, 'h0000FF, 3, 4, 400, 'hFF0000, 5);

        random_traffic(130);
        foreach (pw[p]) begin
            write_reg(blzr_pkg::CFG_WIDTH, pw[p]);
            write_reg(blzr_pkg::CFG_HEIGHT, ph[p]);
            quiet = (p == 1);
            random_traffic(130 + 85 * (p + 1));
        end
        quiet = 0;
        s_valid <= 0;

        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

[bresenham_line_zbuffer_raster_core.f]
rtl/core/blzr_pkg.sv
rtl/core/blzr_ctrl.sv
rtl/core/blzr_dp.sv
rtl/core/bresenham_line_zbuffer_raster_core.sv
verif/blzr_checker.sv
verif/tb_top.sv
